/* design/rigid_body_euler_integrator_assert.svh */
// assertion helpers shared by the integrator modules
`ifndef RIGID_BODY_EULER_INTEGRATOR_ASSERT_SVH
`define RIGID_BODY_EULER_INTEGRATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RBEI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RBEI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rbei_pkg.sv */
package rbei_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int HEADING_W = 19;
    // 2pi in Q32.32
    localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;

    // 2pi rounded to the given number of fraction bits
    function automatic longint unsigned two_pi_q(input int frac);
        return (TWO_PI_Q32 + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_FORCE     = 3'd1,
        KIND_IMPULSE   = 3'd2,
        KIND_IMP_POINT = 3'd3,
        KIND_DRAG      = 3'd4,
        KIND_SET_POS   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        REG_ENABLED    = 2'd0,
        REG_INV_MASS   = 2'd1,
        REG_INV_MOMENT = 2'd2,
        REG_DRAG       = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_ADD1,
        ST_MUL2,
        ST_ADD2,
        ST_MUL3,
        ST_ADD3,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MS_FORCE_DT,
        MS_VEC_IMASS,
        MS_NVEL_DRAG,
        MS_VEL_DT,
        MS_EXT
    } lane_mul_t;

    typedef enum logic [1:0] {
        VOP_NONE,
        VOP_ADD_PROD,
        VOP_ADD_VEC
    } vel_op_t;

    typedef enum logic [1:0] {
        FOP_NONE,
        FOP_ADD_PROD,
        FOP_ADD_VEC,
        FOP_CLEAR
    } force_op_t;

    typedef enum logic [1:0] {
        POP_NONE,
        POP_ADD_PROD,
        POP_LOAD
    } pos_op_t;

    typedef enum logic [1:0] {
        SP_TORQUE_DT,
        SP_RATE_DT,
        SP_DOT_MOMENT
    } spin_mul_t;

    typedef struct packed {
        logic      mul_en;
        lane_mul_t mul_sel;
        vel_op_t   vel_op;
        force_op_t force_op;
        pos_op_t   pos_op;
    } lane_ctrl_t;

    typedef struct packed {
        logic      mul_en;
        spin_mul_t mul_sel;
        logic      add_en;
    } spin_ctrl_t;

    typedef struct packed {
        logic sum_en;
        logic mul1_en;
        logic mul2_en;
        logic fix_en;
    } wrap_ctrl_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        step_time;
        logic signed [31:0] torque;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]     pos_x;
        logic signed [31:0]     pos_y;
        logic signed [31:0]     pos_z;
        logic signed [31:0]     vel_x;
        logic signed [31:0]     vel_y;
        logic signed [31:0]     vel_z;
        logic signed [31:0]     spin_rate;
        logic [HEADING_W-1:0]   heading;
    } out_item_t;

endpackage

/* design/rigid_body_euler_integrator.sv */
// a tick steps through MUL1, ADD1, MUL2, ADD2, MUL3, ADD3, FIX and DONE; an impulse at a point skips FIX;
// every other kind, and every kind while disabled, goes MUL1, ADD1, DONE; one request in flight, next accepted
// the cycle after the result is registered; DONE waits while an earlier result is still held unaccepted
// the tick path is set by two dependent lane multiplies and the heading reduction
// aresetn (synchronous, active low) clears body state and the result valid flag and
// restores enabled=1, inverse_mass=1.0, inverse_moment=0, drag_coefficient=0
`include "rigid_body_euler_integrator_assert.svh"

module rigid_body_euler_integrator #(
    parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  rbei_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rbei_pkg::out_item_t m_data
);
    import rbei_pkg::*;

    state_t     state_reg, state_next;
    in_item_t   item_reg;
    out_item_t  m_data_reg;
    logic       m_valid_reg, m_valid_next;
    logic       enabled_reg;
    logic [31:0] imass_reg, imoment_reg;
    logic signed [31:0] drag_reg;
    logic signed [31:0] dot_reg;

    lane_ctrl_t lane_ctrl;
    spin_ctrl_t spin_ctrl;
    wrap_ctrl_t wrap_ctrl;
    logic       load_out;

    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic [63:0]        prod_x, prod_y;
    logic signed [31:0] rate, spin_prod;
    logic [HEADING_W-1:0] heading;
    logic signed [31:0] rot_x, rot_y;
    logic [63:0]        dot_sum;
    kind_t              kind;
    logic               is_tick, is_pt;
    cfg_reg_t           cfg_sel;
    logic               cfg_wr;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_sel)
            REG_ENABLED:    prdata = {31'd0, enabled_reg};
            REG_INV_MASS:   prdata = imass_reg;
            REG_INV_MOMENT: prdata = imoment_reg;
            REG_DRAG:       prdata = drag_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b1;
            imass_reg   <= 32'd1 << FRAC_BITS;
            imoment_reg <= '0;
            drag_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_ENABLED:    enabled_reg <= pwdata[0];
                REG_INV_MASS:   imass_reg   <= pwdata;
                REG_INV_MOMENT: imoment_reg <= pwdata;
                REG_DRAG:       drag_reg    <= pwdata;
                default:        enabled_reg <= enabled_reg;
            endcase
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign kind    = kind_t'(item_reg.kind);
    assign is_tick = enabled_reg && (kind == KIND_TICK);
    assign is_pt   = enabled_reg && (kind == KIND_IMP_POINT);
    assign s_ready = (state_reg == ST_IDLE);

    // sequencer: next state and lane controls
    always_comb begin
        state_next = state_reg;
        lane_ctrl  = '{mul_en: 1'b0, mul_sel: MS_FORCE_DT, vel_op: VOP_NONE,
                       force_op: FOP_NONE, pos_op: POP_NONE};
        spin_ctrl  = '{mul_en: 1'b0, mul_sel: SP_TORQUE_DT, add_en: 1'b0};
        wrap_ctrl  = '{sum_en: 1'b0, mul1_en: 1'b0, mul2_en: 1'b0, fix_en: 1'b0};
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                lane_ctrl.mul_en = 1'b1;
                if (kind == KIND_IMP_POINT) begin
                    lane_ctrl.mul_sel = MS_VEC_IMASS;
                end else if (kind == KIND_DRAG) begin
                    lane_ctrl.mul_sel = MS_NVEL_DRAG;
                end else begin
                    lane_ctrl.mul_sel = MS_FORCE_DT;
                end
                spin_ctrl.mul_en  = 1'b1;
                spin_ctrl.mul_sel = SP_TORQUE_DT;
                state_next = ST_ADD1;
            end
            ST_ADD1: begin
                if (kind == KIND_SET_POS) begin
                    lane_ctrl.pos_op = POP_LOAD;
                end else if (enabled_reg) begin
                    case (kind)
                        KIND_TICK: begin
                            lane_ctrl.vel_op   = VOP_ADD_PROD;
                            lane_ctrl.force_op = FOP_CLEAR;
                            spin_ctrl.add_en   = 1'b1;
                        end
                        KIND_FORCE:     lane_ctrl.force_op = FOP_ADD_VEC;
                        KIND_IMPULSE:   lane_ctrl.vel_op   = VOP_ADD_VEC;
                        KIND_IMP_POINT: lane_ctrl.vel_op   = VOP_ADD_PROD;
                        KIND_DRAG:      lane_ctrl.force_op = FOP_ADD_PROD;
                        default:        lane_ctrl.vel_op   = VOP_NONE;
                    endcase
                end
                state_next = (is_tick || is_pt) ? ST_MUL2 : ST_DONE;
            end
            ST_MUL2: begin
                lane_ctrl.mul_en  = 1'b1;
                lane_ctrl.mul_sel = is_tick ? MS_VEL_DT : MS_EXT;
                spin_ctrl.mul_en  = 1'b1;
                spin_ctrl.mul_sel = SP_RATE_DT;
                state_next = ST_ADD2;
            end
            ST_ADD2: begin
                if (is_tick) begin
                    lane_ctrl.pos_op = POP_ADD_PROD;
                    wrap_ctrl.sum_en = 1'b1;
                end
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                wrap_ctrl.mul1_en = is_tick;
                spin_ctrl.mul_en  = is_pt;
                spin_ctrl.mul_sel = SP_DOT_MOMENT;
                state_next = ST_ADD3;
            end
            ST_ADD3: begin
                wrap_ctrl.mul2_en = is_tick;
                spin_ctrl.add_en  = is_pt;
                state_next = is_tick ? ST_FIX : ST_DONE;
            end
            ST_FIX: begin
                wrap_ctrl.fix_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // contact lever rotated by 90 degrees: (-(py - pos_y), px - pos_x)
    assign rot_x = pos_y - item_reg.point_y;
    assign rot_y = item_reg.point_x - pos_x;

    // axis lanes
    rbei_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (lane_ctrl),
        .vec              (item_reg.vec_x),
        .step_time        (item_reg.step_time),
        .inverse_mass     (imass_reg),
        .drag_coefficient (drag_reg),
        .ext_a            (item_reg.vec_x),
        .ext_b            (rot_x),
        .pos              (pos_x),
        .vel              (vel_x),
        .prod_lo          (prod_x)
    );

    rbei_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (lane_ctrl),
        .vec              (item_reg.vec_y),
        .step_time        (item_reg.step_time),
        .inverse_mass     (imass_reg),
        .drag_coefficient (drag_reg),
        .ext_a            (item_reg.vec_y),
        .ext_b            (rot_y),
        .pos              (pos_y),
        .vel              (vel_y),
        .prod_lo          (prod_y)
    );

    rbei_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (lane_ctrl),
        .vec              (item_reg.vec_z),
        .step_time        (item_reg.step_time),
        .inverse_mass     (imass_reg),
        .drag_coefficient (drag_reg),
        .ext_a            (32'sd0),
        .ext_b            (32'sd0),
        .pos              (pos_z),
        .vel              (vel_z),
        .prod_lo          ()
    );

    // merge the x and y lever products into the planar torque term
    assign dot_sum = prod_x + prod_y;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADD2) begin
            dot_reg <= dot_sum[FRAC_BITS+31:FRAC_BITS];
        end
    end

    rbei_spin_lane #(.FRAC_BITS(FRAC_BITS)) u_spin (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (spin_ctrl),
        .torque         (item_reg.torque),
        .step_time      (item_reg.step_time),
        .dot            (dot_reg),
        .inverse_moment (imoment_reg),
        .rate           (rate),
        .prod_q         (spin_prod)
    );

    rbei_heading_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (wrap_ctrl),
        .inc     (spin_prod),
        .heading (heading)
    );

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                            vel_x: vel_x, vel_y: vel_y, vel_z: vel_z,
                            spin_rate: rate, heading: heading};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RBEI_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second request taken while busy")
    `RBEI_ASSERT_NXT(a_done_holds, aclk, aresetn, (state_reg == ST_DONE) && m_valid_reg && !m_ready, state_reg == ST_DONE, "result dropped under stall")
    `RBEI_ASSERT_IMP(a_valid_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_DONE), "result raised outside done step")

endmodule

/* design/rbei_axis_lane.sv */
module rbei_axis_lane #(
    parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rbei_pkg::lane_ctrl_t ctrl,
    input  logic signed [31:0]  vec,
    input  logic [30:0]         step_time,
    input  logic [31:0]         inverse_mass,
    input  logic signed [31:0]  drag_coefficient,
    input  logic signed [31:0]  ext_a,
    input  logic signed [31:0]  ext_b,
    output logic signed [31:0]  pos,
    output logic signed [31:0]  vel,
    output logic [63:0]         prod_lo
);
    import rbei_pkg::*;

    logic signed [31:0] pos_reg, pos_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [31:0] force_reg, force_next;
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;
    logic [31:0]        nvel;
    logic [31:0]        prod_q;

    assign nvel   = 32'd0 - vel_reg;
    assign prod_q = prod_reg[FRAC_BITS+31:FRAC_BITS];

    // multiplier operand select
    always_comb begin
        case (ctrl.mul_sel)
            MS_FORCE_DT: begin
                mul_a = {force_reg[31], force_reg};
                mul_b = {2'b00, step_time};
            end
            MS_VEC_IMASS: begin
                mul_a = {vec[31], vec};
                mul_b = {1'b0, inverse_mass};
            end
            MS_NVEL_DRAG: begin
                mul_a = {nvel[31], nvel};
                mul_b = {drag_coefficient[31], drag_coefficient};
            end
            MS_VEL_DT: begin
                mul_a = {vel_reg[31], vel_reg};
                mul_b = {2'b00, step_time};
            end
            MS_EXT: begin
                mul_a = {ext_a[31], ext_a};
                mul_b = {ext_b[31], ext_b};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // state updates
    always_comb begin
        case (ctrl.vel_op)
            VOP_ADD_PROD: vel_next = vel_reg + prod_q;
            VOP_ADD_VEC:  vel_next = vel_reg + vec;
            default:      vel_next = vel_reg;
        endcase
        case (ctrl.force_op)
            FOP_ADD_PROD: force_next = force_reg + prod_q;
            FOP_ADD_VEC:  force_next = force_reg + vec;
            FOP_CLEAR:    force_next = '0;
            default:      force_next = force_reg;
        endcase
        case (ctrl.pos_op)
            POP_ADD_PROD: pos_next = pos_reg + prod_q;
            POP_LOAD:     pos_next = vec;
            default:      pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            vel_reg   <= '0;
            force_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            vel_reg   <= vel_next;
            force_reg <= force_next;
        end
    end

    // product register
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign pos     = pos_reg;
    assign vel     = vel_reg;
    assign prod_lo = prod_reg[63:0];

endmodule

/* design/rbei_spin_lane.sv */
module rbei_spin_lane #(
    parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rbei_pkg::spin_ctrl_t ctrl,
    input  logic signed [31:0]   torque,
    input  logic [30:0]          step_time,
    input  logic signed [31:0]   dot,
    input  logic [31:0]          inverse_moment,
    output logic signed [31:0]   rate,
    output logic signed [31:0]   prod_q
);
    import rbei_pkg::*;

    logic signed [31:0] rate_reg, rate_next;
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;

    // multiplier operand select
    always_comb begin
        case (ctrl.mul_sel)
            SP_TORQUE_DT: begin
                mul_a = {torque[31], torque};
                mul_b = {2'b00, step_time};
            end
            SP_RATE_DT: begin
                mul_a = {rate_reg[31], rate_reg};
                mul_b = {2'b00, step_time};
            end
            SP_DOT_MOMENT: begin
                mul_a = {dot[31], dot};
                mul_b = {1'b0, inverse_moment};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_q    = prod_reg[FRAC_BITS+31:FRAC_BITS];
    assign rate_next = ctrl.add_en ? rate_reg + prod_q : rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= '0;
        end else begin
            rate_reg <= rate_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign rate = rate_reg;

endmodule

/* design/rbei_heading_wrap.sv */
`include "rigid_body_euler_integrator_assert.svh"

module rbei_heading_wrap #(
    parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rbei_pkg::wrap_ctrl_t           ctrl,
    input  logic signed [31:0]             inc,
    output logic [rbei_pkg::HEADING_W-1:0] heading
);
    import rbei_pkg::*;

    localparam longint unsigned TwoPi = two_pi_q(FRAC_BITS);
    localparam int CW = $clog2(TwoPi);
    // sum width: offset old heading plus signed increment stays below 2^SW
    localparam int SW = 34;
    localparam longint unsigned Wraps = ((64'd1 << 31) + TwoPi - 64'd1) / TwoPi;
    localparam longint unsigned Offset = TwoPi * Wraps;
    localparam longint unsigned Recip = (64'd1 << SW) / TwoPi;
    localparam int RW = $clog2(Recip + 64'd1);
    localparam int PW = RW + CW;
    localparam logic [RW-1:0] RecipV = RW'(Recip);
    localparam logic [CW-1:0] TwoPiC = CW'(TwoPi);
    localparam logic [SW-1:0] TwoPiS = SW'(TwoPi);
    localparam logic [SW-1:0] OffsetS = SW'(Offset);

    logic [CW-1:0]    orient_reg, orient_next;
    logic [SW-1:0]    osum_reg;
    logic [SW+RW-1:0] qprod_reg;
    logic [SW-1:0]    qc_reg;
    logic [RW-1:0]    quot;
    logic [PW-1:0]    qc_full;
    logic [SW-1:0]    rem;

    // quotient estimate is low by at most one, so one correction step
    assign quot    = qprod_reg[SW+RW-1:SW];
    assign qc_full = PW'(quot) * PW'(TwoPiC);
    assign rem     = osum_reg - qc_reg;

    always_comb begin
        orient_next = orient_reg;
        if (ctrl.fix_en) begin
            if (rem >= TwoPiS) begin
                orient_next = CW'(rem - TwoPiS);
            end else begin
                orient_next = CW'(rem);
            end
        end
    end

    // reduction pipeline: biased sum, reciprocal multiply, back-multiply
    always_ff @(posedge aclk) begin
        if (ctrl.sum_en) begin
            osum_reg <= SW'(orient_reg) + {{(SW-32){inc[31]}}, inc} + OffsetS;
        end
        if (ctrl.mul1_en) begin
            qprod_reg <= osum_reg * RecipV;
        end
        if (ctrl.mul2_en) begin
            qc_reg <= qc_full[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg <= '0;
        end else begin
            orient_reg <= orient_next;
        end
    end

    assign heading = HEADING_W'(orient_reg);

    `RBEI_ASSERT_IMP(a_orient_range, aclk, aresetn, 1'b1, orient_reg < TwoPiC, "heading out of range")
    `RBEI_ASSERT_NXT(a_fix_updates, aclk, aresetn, !ctrl.fix_en, $stable(orient_reg), "heading moved outside fix step")

endmodule
